[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the moving average regression checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

[design/mmar_pkg.sv]
// ----------------------------------------------------------------------------
// mmar_pkg
// Types and fixed constants of the multichannel moving average regression.
// ----------------------------------------------------------------------------
package mmar_pkg;

  // Number of ADC channels carried by one transfer.
  localparam int NCH         = 5;
  // Field widths fixed by the interface.
  localparam int SAMPLE_W    = 12;
  localparam int OUT_SUM_W   = 16;
  localparam int COEF_W      = 32;
  localparam int HEIGHT_W    = 32;
  // Growth of the product sum over five terms.
  localparam int ACC_GROW    = 3;
  // Digit width of the constant divider.
  localparam int DIGIT_W     = 24;
  localparam int CFG_INDEX_W = 3;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OFFSET = 3'd0,
    REG_GAIN0  = 3'd1,
    REG_GAIN1  = 3'd2,
    REG_GAIN2  = 3'd3,
    REG_GAIN3  = 3'd4,
    REG_GAIN4  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;
    logic [SAMPLE_W-1:0] sample_ch4;
  } in_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height_estimate;
    logic [OUT_SUM_W-1:0]       window_sum_ch0;
    logic [OUT_SUM_W-1:0]       window_sum_ch1;
    logic [OUT_SUM_W-1:0]       window_sum_ch2;
    logic [OUT_SUM_W-1:0]       window_sum_ch3;
    logic [OUT_SUM_W-1:0]       window_sum_ch4;
  } out_t;

  // Reset values of the regression registers (Q8.24).
  localparam coef_t OFFSET_RESET = 32'sd55641637;
  localparam coef_t [NCH-1:0] GAIN_RESET = {
    -32'sd5033, 32'sd1493, 32'sd5033, -32'sd8389, 32'sd10066
  };

endpackage

[design/multichannel_moving_average_regression_top.sv]
// ----------------------------------------------------------------------------
// multichannel_moving_average_regression_top
// Five-channel moving average with a fixed-point linear regression on top.
// ----------------------------------------------------------------------------
// Each input transfer carries one ADC sample per channel. Every channel keeps
// its last WINDOW samples in a ring (a RAM row per slot, all channels side by
// side) and a running sum; the new sample replaces the oldest and the sum is
// corrected by the difference. Each transfer yields one result transfer with
// the five window sums (low 16 bits) and a height estimate in signed Q8.24:
// the offset plus floor(sum of gain times window sum, divided by WINDOW),
// saturated to 32 bits. The block accepts one transfer per clock cycle and
// keeps accepting while a finished result waits at the output, until a
// result reaches the last pipeline stage behind it. An accepted transfer
// passes the sum registers, the product sum stages, the constant divider
// and the output register. The divider resolves one 24-bit digit of the
// biased product sum every two stages. Ring rows carry valid flags cleared
// by reset, so no clearing pass is needed after reset. Configuration writes
// take effect at once and are expected only while no transfer is in flight.
// ----------------------------------------------------------------------------
module multichannel_moving_average_regression_top #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mmar_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mmar_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [mmar_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [mmar_pkg::COEF_W-1:0]         cfg_data_i
);

  // Samples are reduced to SAMPLE_BITS, never beyond the field width.
  localparam int RING_W   = (SAMPLE_BITS < mmar_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : mmar_pkg::SAMPLE_W;
  localparam int SUM_W    = $clog2(WINDOW * ((1 << RING_W) - 1) + 1);
  localparam int PROD_W   = mmar_pkg::COEF_W + SUM_W + 1;
  localparam int ACC_W    = PROD_W + mmar_pkg::ACC_GROW;
  localparam int WIN_W    = $clog2(WINDOW + 1);
  localparam int DIV_W    = ACC_W + WIN_W;
  localparam int NDIG     = (DIV_W + mmar_pkg::DIGIT_W - 1) / mmar_pkg::DIGIT_W;
  // Stages behind the sum registers: four in the product sum, two per digit.
  localparam int LINE_LEN = 4 + 2 * NDIG;
  localparam int OSW      = mmar_pkg::OUT_SUM_W;
  localparam int HW       = mmar_pkg::HEIGHT_W;

  // Configuration registers.
  mmar_pkg::coef_t                      offset_q;
  mmar_pkg::coef_t [mmar_pkg::NCH-1:0]  gain_q;

  // Flow control.
  logic accept;
  logic advance;
  logic out_load;
  logic sums_valid_q;
  logic [LINE_LEN-1:0] vld_line_q;

  // Data path.
  logic [mmar_pkg::NCH-1:0][RING_W-1:0] samples;
  logic [mmar_pkg::NCH-1:0][SUM_W-1:0]  sums;
  logic [mmar_pkg::NCH-1:0][OSW-1:0]    sums_out;
  logic [mmar_pkg::NCH-1:0][OSW-1:0]    sum_line_q [LINE_LEN];
  logic [DIV_W-1:0]                     biased;
  logic [ACC_W-1:0]                     quotient;
  logic signed [ACC_W-1:0]              floor_mean;
  logic signed [ACC_W:0]                height_wide;
  logic signed [HW-1:0]                 height;
  mmar_pkg::out_t                       out_data_q;
  logic                                 out_valid_q;

  // --------------------------------------------------------------------------
  // Configuration port. Indexes past the last register are ignored.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= mmar_pkg::OFFSET_RESET;
      gain_q   <= mmar_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      case (mmar_pkg::cfg_reg_e'(cfg_index_i))
        mmar_pkg::REG_OFFSET: offset_q  <= cfg_data_i;
        mmar_pkg::REG_GAIN0:  gain_q[0] <= cfg_data_i;
        mmar_pkg::REG_GAIN1:  gain_q[1] <= cfg_data_i;
        mmar_pkg::REG_GAIN2:  gain_q[2] <= cfg_data_i;
        mmar_pkg::REG_GAIN3:  gain_q[3] <= cfg_data_i;
        mmar_pkg::REG_GAIN4:  gain_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The whole pipeline moves together and only halts when the
  // last stage holds a result that the output register cannot take, so empty
  // stages close up behind a stalled output and input transfers continue.
  // --------------------------------------------------------------------------
  assign out_load   = vld_line_q[LINE_LEN-1] && (!out_valid_q || !out_stall_i);
  assign advance    = !vld_line_q[LINE_LEN-1] || out_load;
  assign accept     = in_valid_i && advance;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_valid_q <= 1'b0;
      vld_line_q   <= '0;
    end else if (advance) begin
      sums_valid_q <= accept;
      vld_line_q   <= {vld_line_q[LINE_LEN-2:0], sums_valid_q};
    end
  end

  // --------------------------------------------------------------------------
  // Rings and running sums. The updated sums are the first pipeline stage.
  // --------------------------------------------------------------------------
  assign samples[0] = in_data_i.sample_ch0[RING_W-1:0];
  assign samples[1] = in_data_i.sample_ch1[RING_W-1:0];
  assign samples[2] = in_data_i.sample_ch2[RING_W-1:0];
  assign samples[3] = in_data_i.sample_ch3[RING_W-1:0];
  assign samples[4] = in_data_i.sample_ch4[RING_W-1:0];

  mmar_window #(
    .WINDOW (WINDOW),
    .RING_W (RING_W),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .samples_i (samples),
    .sums_o    (sums)
  );

  // The window sums ride alongside the arithmetic in a delay line so that
  // they leave together with their height estimate.
  always_comb begin
    for (int k = 0; k < mmar_pkg::NCH; k++) begin
      sums_out[k] = OSW'(sums[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sum_line_q[0] <= sums_out;
      for (int i = 1; i < LINE_LEN; i++) begin
        sum_line_q[i] <= sum_line_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Products, their sum and the divide by the window length.
  // --------------------------------------------------------------------------
  mmar_mac #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .PROD_W (PROD_W),
    .ACC_W  (ACC_W),
    .DIV_W  (DIV_W)
  ) u_mac (
    .clk_i     (clk_i),
    .advance_i (advance),
    .sums_i    (sums),
    .gain_i    (gain_q),
    .biased_o  (biased)
  );

  mmar_div #(
    .WINDOW (WINDOW),
    .ACC_W  (ACC_W),
    .DIV_W  (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .advance_i  (advance),
    .dividend_i (biased),
    .quotient_o (quotient)
  );

  // Removing the bias of 2^(ACC_W-1) from the quotient is an inversion of its
  // top bit, which leaves the floored mean as a signed number.
  assign floor_mean  = {~quotient[ACC_W-1], quotient[ACC_W-2:0]};
  assign height_wide = {floor_mean[ACC_W-1], floor_mean}
                     + {{(ACC_W-HW+1){offset_q[HW-1]}}, offset_q};

  // Saturate when the bits above the 32-bit result are not a sign extension.
  always_comb begin
    if (height_wide[ACC_W] && !(&height_wide[ACC_W-1:HW-1])) begin
      height = {1'b1, {(HW-1){1'b0}}};
    end else if (!height_wide[ACC_W] && (|height_wide[ACC_W-1:HW-1])) begin
      height = {1'b0, {(HW-1){1'b1}}};
    end else begin
      height = height_wide[HW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.height_estimate <= height;
      out_data_q.window_sum_ch0  <= sum_line_q[LINE_LEN-1][0];
      out_data_q.window_sum_ch1  <= sum_line_q[LINE_LEN-1][1];
      out_data_q.window_sum_ch2  <= sum_line_q[LINE_LEN-1][2];
      out_data_q.window_sum_ch3  <= sum_line_q[LINE_LEN-1][3];
      out_data_q.window_sum_ch4  <= sum_line_q[LINE_LEN-1][4];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[design/mmar_ram.sv]
// ----------------------------------------------------------------------------
// mmar_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mmar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/mmar_window.sv]
// ----------------------------------------------------------------------------
// mmar_window
// Sample rings and running window sums for all channels.
// ----------------------------------------------------------------------------
module mmar_window #(
  parameter int WINDOW = 10,
  parameter int RING_W = 12,
  parameter int SUM_W  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [mmar_pkg::NCH-1:0][RING_W-1:0]   samples_i,
  output logic [mmar_pkg::NCH-1:0][SUM_W-1:0]    sums_o
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int ROW_W  = mmar_pkg::NCH * RING_W;

  logic [SLOT_W-1:0]                          slot_q;
  logic [SLOT_W-1:0]                          slot_next;
  logic [SLOT_W-1:0]                          raddr;
  logic [WINDOW-1:0]                          row_valid_q;
  logic [mmar_pkg::NCH-1:0][RING_W-1:0]       rd_row;
  logic [mmar_pkg::NCH-1:0][RING_W-1:0]       old_row;
  logic [mmar_pkg::NCH-1:0][SUM_W-1:0]        sums_q;
  logic [mmar_pkg::NCH-1:0][SUM_W-1:0]        sums_d;

  assign slot_next = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

  // The read port always points at the slot that the next transfer overwrites.
  assign raddr = accept_i ? slot_next : slot_q;

  mmar_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (slot_q),
    .wdata_i (samples_i),
    .raddr_i (raddr),
    .rdata_o (rd_row)
  );

  // Rows not yet written since reset count as zero.
  assign old_row = row_valid_q[slot_q] ? rd_row : '0;

  always_comb begin
    for (int k = 0; k < mmar_pkg::NCH; k++) begin
      sums_d[k] = sums_q[k] - SUM_W'(old_row[k]) + SUM_W'(samples_i[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      row_valid_q <= '0;
      sums_q      <= '0;
    end else if (accept_i) begin
      slot_q              <= slot_next;
      row_valid_q[slot_q] <= 1'b1;
      sums_q              <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

[design/mmar_mac.sv]
// ----------------------------------------------------------------------------
// mmar_mac
// Coefficient products of the window sums, summed and biased non-negative.
// ----------------------------------------------------------------------------
module mmar_mac #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 16,
  parameter int PROD_W = 49,
  parameter int ACC_W  = 52,
  parameter int DIV_W  = 56
) (
  input  logic                                      clk_i,
  input  logic                                      advance_i,
  input  logic [mmar_pkg::NCH-1:0][SUM_W-1:0]       sums_i,
  input  mmar_pkg::coef_t [mmar_pkg::NCH-1:0]       gain_i,
  output logic [DIV_W-1:0]                          biased_o
);

  // Adding WINDOW * 2^(ACC_W-1) makes the dividend non-negative; the
  // quotient then carries an extra 2^(ACC_W-1), removed at the end.
  localparam logic [DIV_W-1:0] BIAS = DIV_W'(WINDOW) << (ACC_W - 1);

  logic signed [PROD_W-1:0] prod_q [mmar_pkg::NCH];
  logic signed [ACC_W-1:0]  pair_a_q;
  logic signed [ACC_W-1:0]  pair_b_q;
  logic signed [PROD_W-1:0] last_q;
  logic signed [ACC_W-1:0]  total_q;
  logic [DIV_W-1:0]         last_bias_q;
  logic [DIV_W-1:0]         biased_q;

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int k = 0; k < mmar_pkg::NCH; k++) begin
        prod_q[k] <= $signed(gain_i[k]) * $signed({1'b0, sums_i[k]});
      end
      pair_a_q <= {{(ACC_W-PROD_W){prod_q[0][PROD_W-1]}}, prod_q[0]}
                + {{(ACC_W-PROD_W){prod_q[1][PROD_W-1]}}, prod_q[1]};
      pair_b_q <= {{(ACC_W-PROD_W){prod_q[2][PROD_W-1]}}, prod_q[2]}
                + {{(ACC_W-PROD_W){prod_q[3][PROD_W-1]}}, prod_q[3]};
      last_q   <= prod_q[4];
      total_q     <= pair_a_q + pair_b_q;
      last_bias_q <= {{(DIV_W-PROD_W){last_q[PROD_W-1]}}, last_q} + BIAS;
      biased_q    <= {{(DIV_W-ACC_W){total_q[ACC_W-1]}}, total_q} + last_bias_q;
    end
  end

  assign biased_o = biased_q;

endmodule

[design/mmar_div.sv]
// ----------------------------------------------------------------------------
// mmar_div
// Pipelined division by the constant window length, one digit per two stages.
// ----------------------------------------------------------------------------
module mmar_div #(
  parameter int WINDOW = 10,
  parameter int ACC_W  = 52,
  parameter int DIV_W  = 56
) (
  input  logic             clk_i,
  input  logic             advance_i,
  input  logic [DIV_W-1:0] dividend_i,
  output logic [ACC_W-1:0] quotient_o
);

  localparam int DW     = mmar_pkg::DIGIT_W;
  localparam int NDIG   = (DIV_W + DW - 1) / DW;
  localparam int WORD_W = NDIG * DW;
  localparam int REM_W  = $clog2(WINDOW);
  localparam int X_W    = REM_W + DW;
  // floor(2^X_W / WINDOW): the estimate is the true digit or one below it.
  localparam logic [X_W-1:0] RECIP = X_W'((64'd1 << X_W) / 64'(WINDOW));

  logic [WORD_W-1:0] word [NDIG+1];
  logic [REM_W-1:0]  rem  [NDIG+1];

  assign word[0] = WORD_W'(dividend_i);
  assign rem[0]  = '0;

  for (genvar j = 0; j < NDIG; j++) begin : g_digit
    localparam int D = NDIG - 1 - j;

    logic [X_W-1:0]    x;
    logic [2*X_W-1:0]  prod;
    logic [X_W-1:0]    x_q;
    logic [DW-1:0]     est_q;
    logic [WORD_W-1:0] a_word_q;
    logic [X_W-1:0]    part;
    logic [X_W-1:0]    resid;
    logic              fix;
    logic [DW-1:0]     digit;
    logic [WORD_W-1:0] word_d;
    logic [WORD_W-1:0] b_word_q;
    logic [REM_W-1:0]  b_rem_q;

    assign x    = {rem[j], word[j][D*DW +: DW]};
    assign prod = (2*X_W)'(x) * (2*X_W)'(RECIP);

    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        x_q      <= x;
        est_q    <= prod[X_W +: DW];
        a_word_q <= word[j];
      end
    end

    // Correction step: the residual is below twice the divisor.
    assign part  = X_W'(est_q) * X_W'(WINDOW);
    assign resid = x_q - part;
    assign fix   = (resid >= X_W'(WINDOW));
    assign digit = est_q + DW'(fix);

    always_comb begin
      word_d            = a_word_q;
      word_d[D*DW +: DW] = digit;
    end

    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        b_word_q <= word_d;
        b_rem_q  <= fix ? REM_W'(resid - X_W'(WINDOW)) : REM_W'(resid);
      end
    end

    assign word[j+1] = b_word_q;
    assign rem[j+1]  = b_rem_q;
  end

  assign quotient_o = word[NDIG][ACC_W-1:0];

endmodule

[design/mmar_checker.sv]
// ----------------------------------------------------------------------------
// mmar_checker
// Port-level checks of the moving average regression top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmar_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mmar_pkg::out_t out_data_o
);

  logic       in_xfer;
  logic       out_xfer;
  logic [7:0] pending_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // Transfers accepted whose results have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(in_xfer) - 8'(out_xfer);
    end
  end

  `MMAR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `MMAR_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `MMAR_ASSERT_IMP(a_out_pending, clk_i, rst_ni, out_valid_o, pending_q != 8'd0)
  `MMAR_ASSERT_NEXT(a_min_latency, clk_i, rst_ni, in_xfer && (pending_q == 8'd0), !out_valid_o)

endmodule

bind multichannel_moving_average_regression_top mmar_checker u_checker (.*);
